// ===== sv/pcss_pkg.sv =====
// Shared types, constants and BCD helpers for the product counter display unit.
package pcss_pkg;

    typedef logic [3:0][3:0] bcd_t;   // [3] thousands .. [0] units

    typedef struct packed {
        logic sensor_level;
        logic up_button_n;
        logic down_button_n;
        logic clear_button_n;
    } sample_t;

    typedef struct packed {
        logic [7:0]  segment_pattern;
        logic [3:0]  digit_select_n;
        logic        full_flag;
        logic        tens_flag;
        logic [13:0] product_count;
    } result_t;

    typedef struct packed {
        logic [7:0] segment_pattern;
        logic [3:0] digit_select_n;
    } scan_view_t;

    typedef struct packed {
        logic        full_flag;
        logic        tens_flag;
        logic [13:0] product_count;
    } count_view_t;

    localparam logic       CFG_ON_TICKS  = 1'b0;
    localparam logic       CFG_OFF_TICKS = 1'b1;
    localparam logic [6:0] TICKS_RESET   = 7'd10;
    localparam logic [7:0] SEG_BLANK     = 8'hFF;
    localparam logic [3:0] DIGITS_OFF    = 4'hF;

    // active-low segment codes, decimal point off
    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0:    code = 8'hC0;
            4'd1:    code = 8'hF9;
            4'd2:    code = 8'hA4;
            4'd3:    code = 8'hB0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hF8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

    function automatic bcd_t bcd_inc(input bcd_t v);
        bcd_t r;
        logic carry;
        r     = v;
        carry = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (carry) begin
                if (r[i] == 4'd9) begin
                    r[i] = 4'd0;
                end else begin
                    r[i]  = r[i] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        return r;
    endfunction

    function automatic bcd_t bcd_dec(input bcd_t v);
        bcd_t r;
        logic borrow;
        r      = v;
        borrow = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (borrow) begin
                if (r[i] == 4'd0) begin
                    r[i] = 4'd9;
                end else begin
                    r[i]   = r[i] - 4'd1;
                    borrow = 1'b0;
                end
            end
        end
        return r;
    endfunction

    // each digit widened to 14 bits first so the weighted products cannot overflow
    function automatic logic [13:0] bcd_to_bin(input bcd_t v);
        return 14'(v[3]) * 14'd1000 + 14'(v[2]) * 14'd100
             + 14'(v[1]) * 14'd10 + 14'(v[0]);
    endfunction

endpackage

// ===== sv/pcss_scan.sv =====
// Display multiplexer: phase counter, digit position and segment/enable latches.
module pcss_scan
    import pcss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [6:0] on_ticks,
    input  logic [6:0] off_ticks,
    input  bcd_t       shown,
    output scan_view_t view_next
);

    localparam logic [2:0] POS_NONE      = 3'd0;
    localparam logic [2:0] POS_THOUSANDS = 3'd1;
    localparam logic [2:0] POS_HUNDREDS  = 3'd2;
    localparam logic [2:0] POS_TENS      = 3'd3;
    localparam logic [2:0] POS_UNITS     = 3'd4;

    logic [7:0] phase_reg, phase_next;
    logic [2:0] pos_reg, pos_next;
    logic [7:0] seg_reg, seg_next;
    logic [3:0] dig_reg, dig_next;

    always_comb
    begin
        phase_next = phase_reg + 8'd1;
        pos_next   = pos_reg;
        seg_next   = seg_reg;
        dig_next   = dig_reg;
        if (phase_next == {1'b0, off_ticks}) begin
            pos_next = pos_reg + 3'd1;
            case (pos_next)
                POS_THOUSANDS: begin
                    seg_next = seg_code(shown[3]);
                    dig_next = dig_reg & 4'b0111;
                end
                POS_HUNDREDS: begin
                    seg_next = seg_code(shown[2]);
                    dig_next = dig_reg & 4'b1011;
                end
                POS_TENS: begin
                    seg_next = seg_code(shown[1]);
                    dig_next = dig_reg & 4'b1101;
                end
                POS_UNITS: begin
                    seg_next = seg_code(shown[0]);
                    dig_next = dig_reg & 4'b1110;
                    pos_next = POS_NONE;
                end
                default: ;
            endcase
        end else if (phase_next == ({1'b0, off_ticks} + {1'b0, on_ticks})) begin
            seg_next   = SEG_BLANK;
            dig_next   = DIGITS_OFF;
            phase_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= 8'd0;
            pos_reg   <= POS_NONE;
            seg_reg   <= SEG_BLANK;
            dig_reg   <= DIGITS_OFF;
        end else if (step) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            seg_reg   <= seg_next;
            dig_reg   <= dig_next;
        end
    end

    assign view_next.segment_pattern = seg_next;
    assign view_next.digit_select_n  = dig_next;

endmodule

// ===== sv/pcss_count.sv =====
// Product count in BCD: sensor edge detect, button lockout and flags.
module pcss_count
    import pcss_pkg::*;
#(
    parameter int COUNT_LIMIT = 9999
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  sample_t     sample,
    output bcd_t        count_now,
    output count_view_t view_next
);

    localparam bcd_t LIMIT_BCD = {4'((COUNT_LIMIT / 1000) % 10), 4'((COUNT_LIMIT / 100) % 10),
                                  4'((COUNT_LIMIT / 10) % 10), 4'(COUNT_LIMIT % 10)};

    bcd_t count_reg, count_next;
    logic armed_reg, armed_next;
    logic released_reg, released_next;
    logic full_reg, full_next;
    logic tens_reg, tens_next;

    function automatic bcd_t step_up(input bcd_t v);
        return (v == LIMIT_BCD) ? '0 : bcd_inc(v);
    endfunction

    function automatic bcd_t step_down(input bcd_t v);
        return (v == '0) ? LIMIT_BCD : bcd_dec(v);
    endfunction

    always_comb
    begin
        count_next    = count_reg;
        armed_next    = armed_reg;
        released_next = released_reg;
        full_next     = full_reg;
        tens_next     = tens_reg;

        if (sample.sensor_level) begin
            armed_next = 1'b1;
        end else if (armed_reg) begin
            armed_next = 1'b0;
            count_next = step_up(count_next);
            full_next  = (count_next == LIMIT_BCD);
            tens_next  = (count_next[0] == 4'd0);
        end

        if (released_reg) begin
            if (!sample.up_button_n) begin
                released_next = 1'b0;
                count_next    = step_up(count_next);
            end
            if (!sample.down_button_n) begin
                released_next = 1'b0;
                count_next    = step_down(count_next);
            end
            if (!sample.clear_button_n) begin
                released_next = 1'b0;
                count_next    = '0;
            end
        end else if (sample.up_button_n && sample.down_button_n && sample.clear_button_n) begin
            released_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg    <= '0;
            armed_reg    <= 1'b0;
            released_reg <= 1'b0;
            full_reg     <= 1'b0;
            tens_reg     <= 1'b0;
        end else if (step) begin
            count_reg    <= count_next;
            armed_reg    <= armed_next;
            released_reg <= released_next;
            full_reg     <= full_next;
            tens_reg     <= tens_next;
        end
    end

    assign count_now               = count_reg;
    assign view_next.full_flag     = full_next;
    assign view_next.tens_flag     = tens_next;
    assign view_next.product_count = bcd_to_bin(count_next);

endmodule

// ===== sv/product_counter_seven_segment_unit.sv =====
// Top level of the product counter with four-digit multiplexed display.
//
// Each sample item is one tick: sensor level plus three active-low buttons.
// Every item yields exactly one result item with the segment byte, the
// active-low digit enables, the full and tens flags and the count after the
// tick. Throughput is one item per clock unless result_ready stalls. The
// single state-update stage between the input and result registers reads the
// count, display scan and lockout state and writes their next values in the
// same cycle. The result register frees the input side, so a new item is
// taken while a finished result still waits on result_ready. The count is
// held in BCD so the scan picks digits without dividing; product_count is
// converted back to binary on the way out. Config (index 0 on_ticks, index 1
// off_ticks, both reset to 10) should only be written while the unit is idle.
module product_counter_seven_segment_unit
    import pcss_pkg::*;
#(
    parameter int COUNT_LIMIT = 9999
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sample_valid,
    output logic       sample_ready,
    input  sample_t    sample,
    output logic       result_valid,
    input  logic       result_ready,
    output result_t    result,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data
);

    logic [6:0]  on_ticks_reg;
    logic [6:0]  off_ticks_reg;

    // input stage
    logic        in_valid_reg;
    sample_t     in_data_reg;

    // result stage
    logic        res_valid_reg;
    result_t     res_data_reg;

    logic        step;
    bcd_t        count_now;
    scan_view_t  scan_next;
    count_view_t count_next;

    // the held item advances when the result slot is free or being drained
    assign step         = in_valid_reg && (!res_valid_reg || result_ready);
    assign sample_ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            on_ticks_reg  <= TICKS_RESET;
            off_ticks_reg <= TICKS_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_ON_TICKS:  on_ticks_reg  <= cfg_data;
                CFG_OFF_TICKS: off_ticks_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (sample_ready) begin
            in_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_ready && sample_valid) begin
            in_data_reg <= sample;
        end
    end

    // scan runs on the count as it stood before this tick
    pcss_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .on_ticks  (on_ticks_reg),
        .off_ticks (off_ticks_reg),
        .shown     (count_now),
        .view_next (scan_next)
    );

    pcss_count #(
        .COUNT_LIMIT (COUNT_LIMIT)
    ) u_count (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .sample    (in_data_reg),
        .count_now (count_now),
        .view_next (count_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_valid_reg <= 1'b0;
        end else if (step) begin
            res_valid_reg <= 1'b1;
        end else if (result_ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step) begin
            res_data_reg.segment_pattern <= scan_next.segment_pattern;
            res_data_reg.digit_select_n  <= scan_next.digit_select_n;
            res_data_reg.full_flag       <= count_next.full_flag;
            res_data_reg.tens_flag       <= count_next.tens_flag;
            res_data_reg.product_count   <= count_next.product_count;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_data_reg;

endmodule
